@@ rtl/first_exact_substring_match_assert.svh @@
// Assertion macros shared by the checker of the first exact substring match.
// Depends on nothing; every macro samples on clk_i and is disabled in reset.
`ifndef FIRST_EXACT_SUBSTRING_MATCH_ASSERT_SVH
`define FIRST_EXACT_SUBSTRING_MATCH_ASSERT_SVH

`define FESM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define FESM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fesm_pkg.sv @@
// Package for the first exact substring match: sizes, command codes and types.
// Depends on nothing; every other file of the block but the assertion header uses it.
`timescale 1ns / 1ps
`default_nettype none

package fesm_pkg;

  localparam int MaxPattern = 32;
  localparam int MaxText    = 1048576;
  localparam int SymW       = 8;
  localparam int CmdW       = 2;
  localparam int PosW       = 20;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int CountW     = $clog2(MaxText + 1);

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdText   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic shift_text;
    logic shift_pat;
  } shift_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/fesm_in_if.sv @@
// Input channel of the first exact substring match: handshake and item fields.
// Depends on fesm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fesm_in_if;
  logic                       valid;
  logic                       ready;
  logic [fesm_pkg::CmdW-1:0]  command;
  logic [fesm_pkg::SymW-1:0]  symbol;
  logic                       last;

  modport source (output valid, output command, output symbol, output last, input ready);
  modport sink (input valid, input command, input symbol, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/fesm_out_if.sv @@
// Result channel of the first exact substring match: handshake and result fields.
// Depends on fesm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fesm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [fesm_pkg::PosW-1:0]  position;
  logic                       overflow;

  modport source (output valid, output found, output position, output overflow, input ready);
  modport sink (input valid, input found, input position, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/first_exact_substring_match.sv @@
// Latency: a result is offered the cycle after the text symbol marked last is transferred.
// Throughput: one item per cycle; the cell chain compares the whole window each cycle.
// The input stalls only while a result waits in the output register and is not taken.
// Reset (rst_ni low, asynchronous) empties the pattern and the text and drops any result.
// Depends on fesm_pkg, fesm_in_if, fesm_out_if and fesm_chain.
`timescale 1ns / 1ps
`default_nettype none

module first_exact_substring_match (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fesm_in_if.sink   in_i,
  fesm_out_if.source out_o
);

  logic                          accept;
  logic                          is_clr;
  logic                          is_app;
  logic                          is_text;
  logic                          sat;
  logic                          pat_full;
  logic                          all_ok;
  logic                          hit;
  logic                          result;
  fesm_pkg::shift_ctrl_t         ctrl;
  logic [fesm_pkg::CountW-1:0]   count_after;
  logic [fesm_pkg::PosW-1:0]     pos_new;

  logic [fesm_pkg::LenW-1:0]     len_q, len_d;
  logic [fesm_pkg::CountW-1:0]   count_q, count_d;
  logic                          seen_q, seen_d;
  logic [fesm_pkg::PosW-1:0]     pos_q, pos_d;
  logic                          ovf_q, ovf_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q, out_found_d;
  logic [fesm_pkg::PosW-1:0]     out_pos_q, out_pos_d;
  logic                          out_ovf_q, out_ovf_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_clr     = accept && (in_i.command == fesm_pkg::CmdClear);
  assign is_app     = accept && (in_i.command == fesm_pkg::CmdAppend);
  assign is_text    = accept && (in_i.command == fesm_pkg::CmdText);
  assign sat        = count_q == fesm_pkg::CountW'(fesm_pkg::MaxText);
  assign pat_full   = len_q == fesm_pkg::LenW'(fesm_pkg::MaxPattern);

  assign ctrl.shift_text = is_text && !sat;
  assign ctrl.shift_pat  = is_app && !pat_full;

  fesm_chain u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .symbol_i (in_i.symbol),
    .len_i    (len_q),
    .all_ok_o (all_ok)
  );

  assign count_after = count_q + fesm_pkg::CountW'(1);
  assign pos_new     = fesm_pkg::PosW'(count_after - fesm_pkg::CountW'(len_q));
  assign hit         = ctrl.shift_text && !seen_q && (len_q != '0) &&
                       (count_after >= fesm_pkg::CountW'(len_q)) && all_ok;
  assign result      = is_text && in_i.last;

  always_comb begin
    len_d       = len_q;
    count_d     = count_q;
    seen_d      = seen_q || hit;
    pos_d       = hit ? pos_new : pos_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_ovf_d   = out_ovf_q;

    if (is_clr) begin
      len_d = '0;
      ovf_d = 1'b0;
    end
    if (is_app) begin
      if (pat_full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + fesm_pkg::LenW'(1);
      end
    end
    if (is_text) begin
      if (sat) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_after;
      end
    end

    if (result) begin
      out_valid_d = 1'b1;
      out_ovf_d   = ovf_d;
      if (len_q == '0) begin
        out_found_d = 1'b1;
        out_pos_d   = '0;
      end else if (seen_d) begin
        out_found_d = 1'b1;
        out_pos_d   = pos_d;
      end else begin
        out_found_d = 1'b0;
        out_pos_d   = '0;
      end
      count_d = '0;
      seen_d  = 1'b0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      count_q     <= '0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_pos_q;
  assign out_o.overflow = out_ovf_q;

endmodule

`default_nettype wire

@@ rtl/fesm_cell.sv @@
// One cell of the compare chain: holds a text symbol and a pattern symbol.
// Depends on fesm_pkg; both symbols move on to the next cell when shifted.
`timescale 1ns / 1ps
`default_nettype none

module fesm_cell (
  input  wire logic                       clk_i,
  input  wire fesm_pkg::shift_ctrl_t      ctrl_i,
  input  wire logic                       active_i,
  input  wire logic [fesm_pkg::SymW-1:0]  text_i,
  input  wire logic [fesm_pkg::SymW-1:0]  pat_i,
  output logic      [fesm_pkg::SymW-1:0]  text_o,
  output logic      [fesm_pkg::SymW-1:0]  pat_o,
  output logic                            ok_o
);

  logic [fesm_pkg::SymW-1:0] text_q;
  logic [fesm_pkg::SymW-1:0] pat_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_text) begin
      text_q <= text_i;
    end
    if (ctrl_i.shift_pat) begin
      pat_q <= pat_i;
    end
  end

  // The compare looks at the window as it stands once the incoming symbol is in.
  assign ok_o   = !active_i || (text_i == pat_q);
  assign text_o = text_q;
  assign pat_o  = pat_q;

endmodule

`default_nettype wire

@@ rtl/fesm_chain.sv @@
// Row of compare cells holding the text window and the reversed pattern.
// Depends on fesm_pkg and fesm_cell; reports whether the whole pattern matches.
`timescale 1ns / 1ps
`default_nettype none

module fesm_chain (
  input  wire logic                         clk_i,
  input  wire fesm_pkg::shift_ctrl_t        ctrl_i,
  input  wire logic [fesm_pkg::SymW-1:0]    symbol_i,
  input  wire logic [fesm_pkg::LenW-1:0]    len_i,
  output logic                              all_ok_o
);

  logic [fesm_pkg::SymW-1:0]       text_w [fesm_pkg::MaxPattern+1];
  logic [fesm_pkg::SymW-1:0]       pat_w  [fesm_pkg::MaxPattern+1];
  logic [fesm_pkg::MaxPattern-1:0] ok_w;

  assign text_w[0] = symbol_i;
  assign pat_w[0]  = symbol_i;

  for (genvar i = 0; i < fesm_pkg::MaxPattern; i++) begin : g_cell
    fesm_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .active_i (len_i > fesm_pkg::LenW'(i)),
      .text_i   (text_w[i]),
      .pat_i    (pat_w[i]),
      .text_o   (text_w[i+1]),
      .pat_o    (pat_w[i+1]),
      .ok_o     (ok_w[i])
    );
  end

  assign all_ok_o = &ok_w;

endmodule

`default_nettype wire

@@ rtl/fesm_checker.sv @@
// Port-level checker for the first exact substring match, bound to the top level.
// Depends on fesm_pkg and the assertion macros in first_exact_substring_match_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_exact_substring_match_assert.svh"

module fesm_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic [fesm_pkg::CmdW-1:0]  in_command_i,
  input wire logic                       in_last_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic                       out_found_i,
  input wire logic [fesm_pkg::PosW-1:0]  out_position_i,
  input wire logic                       out_overflow_i
);

  // A stalled result keeps its fields until it is transferred.
  `FESM_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_found_i) && $stable(out_position_i) && $stable(out_overflow_i), "stalled result changed")

  // A missing pattern always reports position zero.
  `FESM_ASSERT_IMP(a_miss_pos, out_valid_i && !out_found_i, out_position_i == '0, "missing result with nonzero position")

  // A new result appears only after the transfer of a text symbol marked last.
  `FESM_ASSERT_IMP(a_result_src, $rose(out_valid_i), $past(in_valid_i && in_ready_i && in_last_i && (in_command_i == fesm_pkg::CmdText)), "result without a last text symbol")

  // The input only stalls behind a result that is waiting.
  `FESM_ASSERT_IMP(a_ready, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without a waiting result")

endmodule

bind first_exact_substring_match fesm_checker u_fesm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_found_i    (out_o.found),
  .out_position_i (out_o.position),
  .out_overflow_i (out_o.overflow)
);

`default_nettype wire
